@@ hdl/adsr_pkg.sv @@
// Shared types and constants for the linear ADSR envelope amplitude core.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    localparam int TIME_BITS     = 32;
    localparam int AMP_BITS      = 16;
    localparam int AMP_FRAC_BITS = 15;
    localparam int PROD_BITS     = TIME_BITS + AMP_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int THRESH_SCALE  = 1000;
    localparam int THRESH_BITS   = AMP_BITS + 10;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_AMP      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_TICKS  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_TICKS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUSTAIN_AMP   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_TICKS = 3'd4;

    localparam logic [AMP_BITS-1:0]  RST_PEAK_AMP      = 16'd32768;
    localparam logic [TIME_BITS-1:0] RST_ATTACK_TICKS  = 32'd4800;
    localparam logic [TIME_BITS-1:0] RST_DECAY_TICKS   = 32'd4800;
    localparam logic [AMP_BITS-1:0]  RST_SUSTAIN_AMP   = 16'd26214;
    localparam logic [TIME_BITS-1:0] RST_RELEASE_TICKS = 32'd9600;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_tick;
        logic [TIME_BITS-1:0] on_tick;
        logic [TIME_BITS-1:0] off_tick;
    } in_t;

    typedef struct packed {
        logic [AMP_BITS-1:0] amplitude;
        logic                finished;
    } out_t;

    // Sideband carried next to the first divider.
    typedef struct packed {
        logic [AMP_BITS-1:0]  base;
        logic                 sub;
        logic                 rel_on;
        logic                 rel_kill;
        logic [TIME_BITS-1:0] rel_left;
        logic [TIME_BITS-1:0] rel;
    } side1_t;

    // Sideband carried next to the second divider.
    typedef struct packed {
        logic [AMP_BITS-1:0] held;
        logic                rel_on;
        logic                rel_kill;
    } side2_t;

endpackage

`default_nettype wire

@@ hdl/adsr_envelope_amplitude_core.sv @@
// Top level of the linear ADSR envelope amplitude core.
`timescale 1ns / 1ps
`default_nettype none

// Computes one linear ADSR amplitude (Q1.15) per request from the current,
// note-on and note-off ticks. The core is fully pipelined and accepts one
// request every cycle while the output does not stall. It holds two
// pipelined restoring dividers of 16 stages each (phase ramp, then release
// fade) plus input, operand, multiply and output registers. Configuration
// writes are always taken (cfg_ready is tied high) and must be done while
// the core is empty. A stall on the output freezes the whole pipeline.
module adsr_envelope_amplitude_core
    import adsr_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire [CFG_DATA_BITS-1:0] cfg_data,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  in_t                     in_data,
    output logic                    out_valid,
    input  wire                     out_stall,
    output out_t                    out_data
);

    localparam int NSTEP = AMP_BITS;

    logic [AMP_BITS-1:0]  peak_reg;
    logic [TIME_BITS-1:0] attack_reg;
    logic [TIME_BITS-1:0] decay_reg;
    logic [AMP_BITS-1:0]  sustain_reg;
    logic [TIME_BITS-1:0] release_reg;

    logic en;

    assign cfg_ready = 1'b1;
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg    <= RST_PEAK_AMP;
            attack_reg  <= RST_ATTACK_TICKS;
            decay_reg   <= RST_DECAY_TICKS;
            sustain_reg <= RST_SUSTAIN_AMP;
            release_reg <= RST_RELEASE_TICKS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PEAK_AMP:      peak_reg    <= cfg_data[AMP_BITS-1:0];
                CFG_ATTACK_TICKS:  attack_reg  <= cfg_data[TIME_BITS-1:0];
                CFG_DECAY_TICKS:   decay_reg   <= cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN_AMP:   sustain_reg <= cfg_data[AMP_BITS-1:0];
                CFG_RELEASE_TICKS: release_reg <= cfg_data[TIME_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Stage 1: input register.
    logic s1_valid_reg;
    in_t  s1_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s1_data_reg <= in_data;
    end

    // Stage 2: phase selection and multiplier operands.
    logic [TIME_BITS-1:0] life, t_dec, r_rel;
    logic                 in_attack, in_decay;
    logic [AMP_BITS-1:0]  ma_next, ma_reg;
    logic [TIME_BITS-1:0] mb_next, mb_reg;
    logic [TIME_BITS-1:0] den1_next, den1_reg;
    side1_t               side_s2_next, side_s2_reg;
    logic                 s2_valid_reg;

    always_comb
    begin
        life = (s1_data_reg.now_tick >= s1_data_reg.on_tick) ?
               s1_data_reg.now_tick - s1_data_reg.on_tick : '0;
        t_dec = (attack_reg < life) ? life - attack_reg : '0;
        in_attack = (attack_reg != '0) && (life <= attack_reg);
        in_decay = (decay_reg != '0) && (t_dec <= decay_reg) &&
                   ((t_dec != '0) || (attack_reg == '0));
        r_rel = s1_data_reg.now_tick - s1_data_reg.off_tick;

        side_s2_next.rel_on   = s1_data_reg.now_tick > s1_data_reg.off_tick;
        side_s2_next.rel_kill = (release_reg == '0) || (r_rel >= release_reg);
        side_s2_next.rel_left = release_reg - r_rel;
        side_s2_next.rel      = release_reg;

        if (in_attack)
        begin
            ma_next           = peak_reg;
            mb_next           = life;
            den1_next         = attack_reg;
            side_s2_next.base = '0;
            side_s2_next.sub  = 1'b0;
        end
        else if (in_decay)
        begin
            mb_next           = t_dec;
            den1_next         = decay_reg;
            side_s2_next.base = peak_reg;
            if (sustain_reg <= peak_reg)
            begin
                ma_next          = peak_reg - sustain_reg;
                side_s2_next.sub = 1'b1;
            end
            else
            begin
                ma_next          = sustain_reg - peak_reg;
                side_s2_next.sub = 1'b0;
            end
        end
        else
        begin
            ma_next           = '0;
            mb_next           = '0;
            den1_next         = TIME_BITS'(1);
            side_s2_next.base = sustain_reg;
            side_s2_next.sub  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg      <= ma_next;
            mb_reg      <= mb_next;
            den1_reg    <= den1_next;
            side_s2_reg <= side_s2_next;
        end
    end

    // Stage 3: ramp product.
    logic                 s3_valid_reg;
    logic [PROD_BITS-1:0] num1_reg;
    logic [TIME_BITS-1:0] den1_s3_reg;
    side1_t               side_s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg    <= PROD_BITS'(ma_reg) * PROD_BITS'(mb_reg);
            den1_s3_reg <= den1_reg;
            side_s3_reg <= side_s2_reg;
        end
    end

    // First divider. The quotient never exceeds 16 bits, so the upper
    // numerator bits already sit below the divisor and only 16 steps remain.
    logic                 d1_valid [0:NSTEP];
    logic [TIME_BITS-1:0] d1_rem   [0:NSTEP];
    logic [AMP_BITS-1:0]  d1_low   [0:NSTEP];
    logic [AMP_BITS-1:0]  d1_q     [0:NSTEP];
    logic [TIME_BITS-1:0] d1_den   [0:NSTEP];
    side1_t               d1_side  [0:NSTEP];

    assign d1_valid[0] = s3_valid_reg;
    assign d1_rem[0]   = num1_reg[PROD_BITS-1:AMP_BITS];
    assign d1_low[0]   = num1_reg[AMP_BITS-1:0];
    assign d1_q[0]     = '0;
    assign d1_den[0]   = den1_s3_reg;
    assign d1_side[0]  = side_s3_reg;

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_div1
        logic [TIME_BITS:0] trial;
        logic               ge;

        assign trial = {d1_rem[k], d1_low[k][AMP_BITS-1]};
        assign ge    = trial >= {1'b0, d1_den[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d1_valid[k+1] <= 1'b0;
            else if (en)
                d1_valid[k+1] <= d1_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_rem[k+1]  <= ge ? TIME_BITS'(trial - {1'b0, d1_den[k]}) :
                                trial[TIME_BITS-1:0];
                d1_low[k+1]  <= {d1_low[k][AMP_BITS-2:0], 1'b0};
                d1_q[k+1]    <= {d1_q[k][AMP_BITS-2:0], ge};
                d1_den[k+1]  <= d1_den[k];
                d1_side[k+1] <= d1_side[k];
            end
        end
    end

    // Stage 4: held amplitude and release operands.
    logic                 s4_valid_reg;
    logic [AMP_BITS-1:0]  held_reg;
    logic [TIME_BITS-1:0] rel_left_reg;
    logic [TIME_BITS-1:0] den2_reg;
    side2_t               side_s4_reg;
    logic [AMP_BITS-1:0]  held_next;
    logic                 rel_div;

    assign held_next = d1_side[NSTEP].sub ? d1_side[NSTEP].base - d1_q[NSTEP] :
                       d1_side[NSTEP].base + d1_q[NSTEP];
    assign rel_div   = d1_side[NSTEP].rel_on && !d1_side[NSTEP].rel_kill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= d1_valid[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            held_reg             <= held_next;
            rel_left_reg         <= rel_div ? d1_side[NSTEP].rel_left : '0;
            den2_reg             <= rel_div ? d1_side[NSTEP].rel : TIME_BITS'(1);
            side_s4_reg.held     <= held_next;
            side_s4_reg.rel_on   <= d1_side[NSTEP].rel_on;
            side_s4_reg.rel_kill <= d1_side[NSTEP].rel_kill;
        end
    end

    // Stage 5: release product.
    logic                 s5_valid_reg;
    logic [PROD_BITS-1:0] num2_reg;
    logic [TIME_BITS-1:0] den2_s5_reg;
    side2_t               side_s5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num2_reg    <= PROD_BITS'(held_reg) * PROD_BITS'(rel_left_reg);
            den2_s5_reg <= den2_reg;
            side_s5_reg <= side_s4_reg;
        end
    end

    // Second divider, same structure as the first.
    logic                 d2_valid [0:NSTEP];
    logic [TIME_BITS-1:0] d2_rem   [0:NSTEP];
    logic [AMP_BITS-1:0]  d2_low   [0:NSTEP];
    logic [AMP_BITS-1:0]  d2_q     [0:NSTEP];
    logic [TIME_BITS-1:0] d2_den   [0:NSTEP];
    side2_t               d2_side  [0:NSTEP];

    assign d2_valid[0] = s5_valid_reg;
    assign d2_rem[0]   = num2_reg[PROD_BITS-1:AMP_BITS];
    assign d2_low[0]   = num2_reg[AMP_BITS-1:0];
    assign d2_q[0]     = '0;
    assign d2_den[0]   = den2_s5_reg;
    assign d2_side[0]  = side_s5_reg;

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_div2
        logic [TIME_BITS:0] trial;
        logic               ge;

        assign trial = {d2_rem[k], d2_low[k][AMP_BITS-1]};
        assign ge    = trial >= {1'b0, d2_den[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d2_valid[k+1] <= 1'b0;
            else if (en)
                d2_valid[k+1] <= d2_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d2_rem[k+1]  <= ge ? TIME_BITS'(trial - {1'b0, d2_den[k]}) :
                                trial[TIME_BITS-1:0];
                d2_low[k+1]  <= {d2_low[k][AMP_BITS-2:0], 1'b0};
                d2_q[k+1]    <= {d2_q[k][AMP_BITS-2:0], ge};
                d2_den[k+1]  <= d2_den[k];
                d2_side[k+1] <= d2_side[k];
            end
        end
    end

    // Output stage: release selection and the 0.001 threshold.
    logic [AMP_BITS-1:0] rel_amp;
    logic                below;
    out_t                out_next;
    out_t                out_reg;
    logic                out_valid_reg;

    assign rel_amp = d2_side[NSTEP].rel_kill ? '0 : d2_q[NSTEP];
    assign below   = (THRESH_BITS'(rel_amp) * THRESH_BITS'(THRESH_SCALE)) <
                     (THRESH_BITS'(1) << AMP_FRAC_BITS);

    always_comb
    begin
        if (!d2_side[NSTEP].rel_on)
        begin
            out_next.amplitude = d2_side[NSTEP].held;
            out_next.finished  = 1'b0;
        end
        else if (below)
        begin
            out_next.amplitude = '0;
            out_next.finished  = 1'b1;
        end
        else
        begin
            out_next.amplitude = rel_amp;
            out_next.finished  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d2_valid[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ test/adsr_envelope_amplitude_core_tb.sv @@
// Self-checking testbench for the linear ADSR envelope amplitude core.
`timescale 1ns / 1ps

module adsr_envelope_amplitude_core_tb;
    import adsr_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 48;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    in_t                      in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    out_t                     out_data;

    // Shadow copy of the envelope registers.
    logic [AMP_BITS-1:0]  peak_reg;
    logic [TIME_BITS-1:0] attack_reg;
    logic [TIME_BITS-1:0] decay_reg;
    logic [AMP_BITS-1:0]  sustain_reg;
    logic [TIME_BITS-1:0] release_reg;

    out_t expected_amps[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    bit   send_burst = 0;
    bit   recv_burst = 0;

    adsr_envelope_amplitude_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Amplitude held before any release, as a function of note lifetime.
    function automatic longint unsigned held_level(longint unsigned life);
        longint unsigned a;
        longint unsigned d;
        longint unsigned pk;
        longint unsigned sus;
        longint unsigned t;
        a = attack_reg;
        d = decay_reg;
        pk = peak_reg;
        sus = sustain_reg;
        if (a != 0 && life <= a)
            return (life * pk) / a;
        t = life - ((a < life) ? a : life);
        if (d != 0 && t <= d && (t > 0 || a == 0))
        begin
            if (sus <= pk)
                return pk - ((pk - sus) * t) / d;
            return pk + ((sus - pk) * t) / d;
        end
        return sus;
    endfunction

    function automatic out_t envelope_of(in_t req);
        longint unsigned now_t;
        longint unsigned on_t;
        longint unsigned off_t;
        longint unsigned rel;
        longint unsigned r;
        longint unsigned amp;
        out_t res;
        now_t = req.now_tick;
        on_t = req.on_tick;
        off_t = req.off_tick;
        rel = release_reg;
        amp = held_level((now_t >= on_t) ? now_t - on_t : 0);
        res.finished = 1'b0;
        if (now_t > off_t)
        begin
            r = now_t - off_t;
            if (rel == 0 || r >= rel)
                amp = 0;
            else
                amp = (amp * (rel - r)) / rel;
            if (amp * THRESH_SCALE < (64'd1 << AMP_FRAC_BITS))
            begin
                amp = 0;
                res.finished = 1'b1;
            end
        end
        res.amplitude = amp[AMP_BITS-1:0];
        return res;
    endfunction

    task automatic send_request(in_t req);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        expected_amps.insert(expected_amps.size(), envelope_of(req));
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_amps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so writes can follow back to back; the caller
    // drops it after the last one.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PEAK_AMP:      peak_reg = val[AMP_BITS-1:0];
            CFG_ATTACK_TICKS:  attack_reg = val;
            CFG_DECAY_TICKS:   decay_reg = val;
            CFG_SUSTAIN_AMP:   sustain_reg = val[AMP_BITS-1:0];
            CFG_RELEASE_TICKS: release_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_envelope(logic [15:0] pk, logic [31:0] a, logic [31:0] d,
                                logic [15:0] sus, logic [31:0] rel);
        wait_idle();
        write_reg(CFG_PEAK_AMP, {16'd0, pk});
        write_reg(CFG_ATTACK_TICKS, a);
        write_reg(CFG_DECAY_TICKS, d);
        write_reg(CFG_SUSTAIN_AMP, {16'd0, sus});
        write_reg(CFG_RELEASE_TICKS, rel);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint unsigned wide_rand();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly notes placed around the phase edges of the current envelope,
    // with some fully random ticks mixed in.
    function automatic in_t random_note();
        in_t req;
        longint unsigned span;
        longint unsigned life;
        longint unsigned r;
        int kind;
        kind = $urandom_range(0, 9);
        req.on_tick = $urandom();
        if (kind < 2)
        begin
            req.now_tick = $urandom();
            req.off_tick = $urandom();
            return req;
        end
        span = longint'(attack_reg) + longint'(decay_reg) + 16;
        case ($urandom_range(0, 3))
            0: life = $urandom_range(0, 8);
            1: life = attack_reg + $urandom_range(0, 4) - 2;
            2: life = attack_reg + decay_reg + $urandom_range(0, 4) - 2;
            default: life = wide_rand() % span;
        endcase
        req.now_tick = req.on_tick + life[31:0];
        if (kind < 5)
            req.off_tick = req.now_tick + $urandom_range(0, 1000);
        else
        begin
            if ($urandom_range(0, 2) == 0)
                r = release_reg + $urandom_range(0, 3) - 1;
            else
                r = wide_rand() % (longint'(release_reg) + 16);
            req.off_tick = req.now_tick - r[31:0];
        end
        return req;
    endfunction

    task automatic test_directed_defaults();
        send_request('{now_tick: 32'd100, on_tick: 32'd200, off_tick: 32'd1000});
        send_request('{now_tick: 32'd0, on_tick: 32'd0, off_tick: 32'd0});
        send_request('{now_tick: 32'd2400, on_tick: 32'd0, off_tick: 32'hFFFF_FFFF});
        send_request('{now_tick: 32'd4800, on_tick: 32'd0, off_tick: 32'd4800});
        send_request('{now_tick: 32'd4801, on_tick: 32'd0, off_tick: 32'd9000});
        send_request('{now_tick: 32'd9600, on_tick: 32'd0, off_tick: 32'd9600});
        send_request('{now_tick: 32'd9601, on_tick: 32'd0, off_tick: 32'd9600});
        send_request('{now_tick: 32'd20000, on_tick: 32'd0, off_tick: 32'd10400});
        send_request('{now_tick: 32'd19599, on_tick: 32'd0, off_tick: 32'd10000});
        send_request('{now_tick: 32'd19600, on_tick: 32'd0, off_tick: 32'd10000});
        send_request('{now_tick: 32'hFFFF_FFFF, on_tick: 32'hFFFF_FFFF,
                       off_tick: 32'hFFFF_FFFF});
        send_request('{now_tick: 32'hFFFF_FFFF, on_tick: 32'd0, off_tick: 32'd0});
        send_request('{now_tick: 32'hFFFF_FFFF, on_tick: 32'd0,
                       off_tick: 32'hFFFF_FFFE});
    endtask

    task automatic test_skipped_phases();
        // Zero attack, decay and release: sustain from life 0 onward,
        // and an instant finish past note-off.
        set_envelope(16'd32768, 32'd0, 32'd0, 16'd16384, 32'd0);
        send_request('{now_tick: 32'd50, on_tick: 32'd50, off_tick: 32'd60});
        send_request('{now_tick: 32'd51, on_tick: 32'd50, off_tick: 32'd60});
        send_request('{now_tick: 32'd61, on_tick: 32'd50, off_tick: 32'd60});
        set_envelope(16'd20000, 32'd0, 32'd10, 16'd30000, 32'd5);
        send_request('{now_tick: 32'd0, on_tick: 32'd0, off_tick: 32'd9});
        send_request('{now_tick: 32'd5, on_tick: 32'd0, off_tick: 32'd9});
        send_request('{now_tick: 32'd11, on_tick: 32'd0, off_tick: 32'd9});
        // An unused register index must leave every setting alone.
        wait_idle();
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'd0);
        cfg_valid <= 1'b0;
        send_request('{now_tick: 32'd12, on_tick: 32'd0, off_tick: 32'd9});
    endtask

    task automatic random_phase(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 63) == 0)
                send_burst = !send_burst;
            send_request(random_note());
        end
    endtask

    task automatic test_random_envelopes();
        set_envelope(RST_PEAK_AMP, RST_ATTACK_TICKS, RST_DECAY_TICKS,
                     RST_SUSTAIN_AMP, RST_RELEASE_TICKS);
        random_phase(120);
        set_envelope(16'd32768, 32'd10, 32'd7, 16'd20000, 32'd13);
        random_phase(120);
        set_envelope(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF);
        random_phase(100);
        set_envelope(16'd0, 32'd1, 32'd1, 16'd32768, 32'd1);
        random_phase(100);
        set_envelope(16'd1000, 32'd3, 32'd0, 16'hFFFF, 32'd100000);
        random_phase(100);
        repeat (3)
        begin
            set_envelope(16'($urandom()), $urandom_range(0, 5000),
                         $urandom_range(0, 5000), 16'($urandom()),
                         $urandom_range(0, 20000));
            random_phase(90);
        end
    endtask

    // Result side: checks every accepted result and draws a stall after each one.
    always @(posedge clk)
    begin
        int n;
        out_t exp_res;
        if (rst_n)
        begin
            n = stall_left;
            if (out_valid && !out_stall)
            begin
                if (expected_amps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result amplitude=%0d finished=%0d",
                                 out_data.amplitude, out_data.finished);
                end
                else
                begin
                    exp_res = expected_amps.pop_front();
                    if (out_data.amplitude !== exp_res.amplitude ||
                        out_data.finished !== exp_res.finished)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected amplitude=%0d finished=%0d, ",
                                      "got amplitude=%0d finished=%0d"},
                                     exp_res.amplitude, exp_res.finished,
                                     out_data.amplitude, out_data.finished);
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
                n = recv_burst ? 0 : $urandom_range(0, 15);
            end
            else if (n > 0)
                n--;
            stall_left <= n;
            out_stall <= (n != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("adsr_envelope_amplitude_core_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        peak_reg = RST_PEAK_AMP;
        attack_reg = RST_ATTACK_TICKS;
        decay_reg = RST_DECAY_TICKS;
        sustain_reg = RST_SUSTAIN_AMP;
        release_reg = RST_RELEASE_TICKS;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_skipped_phases();
        test_random_envelopes();
        wait_idle();
        if (mismatches == 0)
            $display("adsr_envelope_amplitude_core_tb OK");
        else
            $display("adsr_envelope_amplitude_core_tb NOT OK");
        $finish;
    end

endmodule

@@ adsr_envelope_amplitude_core.f @@
hdl/adsr_pkg.sv
hdl/adsr_envelope_amplitude_core.sv
test/adsr_envelope_amplitude_core_tb.sv
